// ----- sv/trilinear_grid_interpolator_defines.svh -----
// Assertion macros used by the interpolator controller
`ifndef TRILINEAR_GRID_INTERPOLATOR_DEFINES_SVH
`define TRILINEAR_GRID_INTERPOLATOR_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define TGI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define TGI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tgi_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the trilinear grid interpolator
package tgi_pkg;

    localparam int GRID_AW   = 16;
    localparam int CNT_W     = 9;
    localparam int IDX_W     = 8;
    localparam int NUM_W     = 49;
    localparam int DEN_W     = 33;
    localparam int DIV_STEPS = 49;
    localparam int DIV_CW    = 6;
    localparam int CFG_IW    = 2;
    localparam int CFG_DW    = 7;

    localparam logic [CFG_IW-1:0] CFG_T_COUNT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_X_COUNT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_Z_COUNT = 2'd2;

    typedef enum logic [2:0] {
        CMD_LOAD_T    = 3'd0,
        CMD_LOAD_X    = 3'd1,
        CMD_LOAD_Z    = 3'd2,
        CMD_LOAD_CELL = 3'd3,
        CMD_QUERY     = 3'd4
    } cmd_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_INDEX,
        ST_FETCH0,
        ST_FETCH1,
        ST_FETCH2,
        ST_ADDR1,
        ST_ADDR2,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CORNER,
        ST_CORNER_TAIL,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        AX_T = 2'd0,
        AX_X = 2'd1,
        AX_Z = 2'd2
    } axis_t;

    typedef enum logic [1:0] {
        RS_SCAN = 2'd0,
        RS_LO   = 2'd1,
        RS_HI   = 2'd2
    } rsel_t;

    typedef struct packed {
        logic               clear_we;
        logic [GRID_AW-1:0] clr_addr;
        logic               start_query;
        logic               scan_en;
        logic [CNT_W-1:0]   scan_k;
        logic               mk_index;
        rsel_t              rsel;
        logic               cap_lo;
        logic               cap_hi;
        logic               addr1;
        logic               addr2;
        logic               div_start;
        logic               div_store;
        axis_t              axis;
        logic               corner_en;
        logic [2:0]         corner;
        logic               mul_lo;
        logic               mul_hi;
        logic               blend_sum;
        logic               fin;
        logic [2:0]         step;
        logic               out_load;
    } tgi_ctl_t;

    typedef struct packed {
        logic scan_last;
        logic div_done;
        logic out_free;
    } tgi_sts_t;

endpackage

// ----- sv/trilinear_grid_interpolator.sv -----
`timescale 1ns / 1ps
// Top level of the trilinear grid interpolator
//
// Input channel (in_valid/in_ready): each transfer carries a command. Load
// commands write one t, x or z axis point or one grid cell and are taken back
// to back while idle. A query finds the cell on each axis, forms three weights
// and blends the eight corners into one result on the output channel
// (out_valid/out_ready); loads never produce a result.
// The axis scan reads one point per cycle from all three axis memories, the
// shared bit-serial divider forms the three weights in turn, the grid memory
// port reads eight corners, and a split multiplier runs seven blends, each
// through the mul_lo, mul_hi, sum and fin states. One query is in work at a
// time; its result sits in an output register, so the next command is taken
// while the receiver stalls, and a new result waits until that register frees
// up. Configuration (cfg_valid, always ready) sets the point counts.
// After reset the loaded-cell map is swept clear, one cell per cycle over all
// 65536 cells, with in_ready low; the counts reset to 2.
module trilinear_grid_interpolator
    import tgi_pkg::*;
#(
    parameter int T_POINTS    = 16,
    parameter int X_POINTS    = 64,
    parameter int Z_POINTS    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic [15:0]        address,
    input  logic signed [31:0] load_value,
    input  logic signed [31:0] query_t,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] interpolated,
    output logic               missing_corner,
    output logic               saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_IW-1:0]  cfg_index,
    input  logic [CFG_DW-1:0]  cfg_data
);

    tgi_ctl_t ctl;
    tgi_sts_t st;

    // Configuration writes are taken at once
    assign cfg_ready = 1'b1;

    tgi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .ctl      (ctl),
        .st       (st)
    );

    tgi_datapath #(
        .T_POINTS    (T_POINTS),
        .X_POINTS    (X_POINTS),
        .Z_POINTS    (Z_POINTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .st             (st),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .address        (address),
        .load_value     (load_value),
        .query_t        (query_t),
        .query_x        (query_x),
        .query_z        (query_z),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .interpolated   (interpolated),
        .missing_corner (missing_corner),
        .saturated      (saturated)
    );

endmodule

// ----- sv/tgi_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read
module tgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tgi_div.sv -----
`timescale 1ns / 1ps
// Bit-serial signed divider that forms one Q16.16 weight
module tgi_div
    import tgi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic                    done,
    output logic [31:0]             w,
    output logic                    ovf
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W:0]    rem_reg;
    logic [DEN_W-1:0]  dmag_reg;
    logic              neg_reg;
    logic              zero_reg;

    logic [DEN_W:0]    shifted;
    logic [DEN_W+1:0]  diff;
    logic              fits;
    logic [NUM_W-1:0]  nmag;
    logic [DEN_W-1:0]  dmag;

    // Magnitudes of the operands
    assign nmag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign dmag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

    // One restoring step
    assign shifted = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dmag_reg};
    assign fits    = !diff[DEN_W+1];

    // Sequence control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Load operands, then shift one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= nmag;
            rem_reg  <= '0;
            dmag_reg <= dmag;
            neg_reg  <= num[NUM_W-1] ^ den[DEN_W-1];
            zero_reg <= (den == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DEN_W:0] : shifted;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    // Sign and clip the quotient
    always_comb
    begin
        ovf = 1'b0;
        w   = '0;
        if (!zero_reg)
        begin
            if (neg_reg)
            begin
                ovf = (|quo_reg[NUM_W-1:32]) || (quo_reg[31] && (|quo_reg[30:0]));
                w   = ovf ? 32'h8000_0000 : 32'(-quo_reg[31:0]);
            end
            else
            begin
                ovf = |quo_reg[NUM_W-1:31];
                w   = ovf ? 32'h7FFF_FFFF : quo_reg[31:0];
            end
        end
    end

    assign done = done_reg;

endmodule

// ----- sv/tgi_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: axis and grid stores, cell search, weights, blend and output register
module tgi_datapath
    import tgi_pkg::*;
#(
    parameter int T_POINTS    = 16,
    parameter int X_POINTS    = 64,
    parameter int Z_POINTS    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tgi_ctl_t            ctl,
    output tgi_sts_t            st,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [2:0]          command,
    input  logic [15:0]         address,
    input  logic signed [31:0]  load_value,
    input  logic signed [31:0]  query_t,
    input  logic signed [31:0]  query_x,
    input  logic signed [31:0]  query_z,
    input  logic                cfg_valid,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic signed [31:0]  interpolated,
    output logic                missing_corner,
    output logic                saturated
);

    localparam int TAW      = $clog2(T_POINTS);
    localparam int XAW      = $clog2(X_POINTS);
    localparam int ZAW      = $clog2(Z_POINTS);
    localparam int SAT_BITS = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam logic signed [50:0] SAT_MAX = 51'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
    localparam logic signed [50:0] SAT_MIN = 51'(-(64'sd1 <<< (SAT_BITS - 1)));

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c,
                                                   input logic [CNT_W-1:0] depth);
        logic [CNT_W-1:0] n;
        begin
            n = c;
            if (c < CNT_W'(2))
            begin
                n = CNT_W'(2);
            end
            else if (c > depth)
            begin
                n = depth;
            end
            return n;
        end
    endfunction

    function automatic logic [IDX_W-1:0] cell_index(input logic [CNT_W-1:0] c,
                                                    input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] i;
        begin
            i = (c == '0) ? '0 : c - 1'b1;
            if (i > n - CNT_W'(2))
            begin
                i = n - CNT_W'(2);
            end
            return i[IDX_W-1:0];
        end
    endfunction

    logic                take;
    logic [4:0]          t_count_reg;
    logic [6:0]          x_count_reg;
    logic [6:0]          z_count_reg;
    logic [CNT_W-1:0]    nt, nx, nz, nmax;

    logic signed [31:0]  qt_reg, qx_reg, qz_reg;
    logic [CNT_W-1:0]    ct_reg, cx_reg, cz_reg;
    logic                incl_t_reg, incl_x_reg, incl_z_reg;
    logic [IDX_W-1:0]    it_reg, ix_reg, iz_reg;
    logic [IDX_W-1:0]    it1, ix1, iz1;
    logic signed [31:0]  t_lo_reg, t_hi_reg, x_lo_reg, x_hi_reg, z_lo_reg, z_hi_reg;
    logic [GRID_AW-1:0]  row_reg, plane_reg, base_reg, corner_addr;
    logic signed [31:0]  wt_reg, wx_reg, wz_reg;
    logic                sat_reg, miss_reg;
    logic                corner_v_reg;
    logic [2:0]          corner_j_reg;
    logic [31:0]         c_reg [8];
    logic signed [48:0]  plo_reg, phi_reg;
    logic signed [65:0]  sum_reg;
    logic                out_valid_reg;
    logic [31:0]         interp_reg;
    logic                miss_out_reg, sat_out_reg;

    logic                t_we, x_we, z_we, cell_we;
    logic [TAW-1:0]      t_ra;
    logic [XAW-1:0]      x_ra;
    logic [ZAW-1:0]      z_ra;
    logic [31:0]         t_rd, x_rd, z_rd, grid_rd;
    logic                loaded_rd;
    logic                loaded_we;
    logic [GRID_AW-1:0]  loaded_wa;

    logic signed [31:0]  q_sel, lo_sel, hi_sel;
    logic signed [32:0]  num33, den33;
    logic                div_done;
    logic [31:0]         div_w;
    logic                div_ovf;

    logic signed [31:0]  w_sel;
    logic signed [32:0]  d_diff;
    logic signed [48:0]  plo_prod, phi_prod;
    logic signed [50:0]  blend_raw;
    logic [31:0]         blend_res;
    logic                blend_clip;
    logic [2:0]          dst;

    assign take = in_valid && in_ready;

    // Effective point counts
    assign nt   = eff_count(CNT_W'(t_count_reg), CNT_W'(T_POINTS));
    assign nx   = eff_count(CNT_W'(x_count_reg), CNT_W'(X_POINTS));
    assign nz   = eff_count(CNT_W'(z_count_reg), CNT_W'(Z_POINTS));
    assign nmax = (nt > nx) ? ((nt > nz) ? nt : nz) : ((nx > nz) ? nx : nz);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_count_reg <= 5'd2;
            x_count_reg <= 7'd2;
            z_count_reg <= 7'd2;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_T_COUNT)
            begin
                t_count_reg <= cfg_data[4:0];
            end
            if (cfg_index == CFG_X_COUNT)
            begin
                x_count_reg <= cfg_data[6:0];
            end
            if (cfg_index == CFG_Z_COUNT)
            begin
                z_count_reg <= cfg_data[6:0];
            end
        end
    end

    // Load write enables
    assign t_we    = take && (command == CMD_LOAD_T) && (32'(address) < 32'(T_POINTS));
    assign x_we    = take && (command == CMD_LOAD_X) && (32'(address) < 32'(X_POINTS));
    assign z_we    = take && (command == CMD_LOAD_Z) && (32'(address) < 32'(Z_POINTS));
    assign cell_we = take && (command == CMD_LOAD_CELL);

    // Axis read address: scan index, lower point or upper point
    assign it1 = it_reg + 1'b1;
    assign ix1 = ix_reg + 1'b1;
    assign iz1 = iz_reg + 1'b1;

    always_comb
    begin
        unique case (ctl.rsel)
            RS_LO:
            begin
                t_ra = it_reg[TAW-1:0];
                x_ra = ix_reg[XAW-1:0];
                z_ra = iz_reg[ZAW-1:0];
            end
            RS_HI:
            begin
                t_ra = it1[TAW-1:0];
                x_ra = ix1[XAW-1:0];
                z_ra = iz1[ZAW-1:0];
            end
            default:
            begin
                t_ra = ctl.scan_k[TAW-1:0];
                x_ra = ctl.scan_k[XAW-1:0];
                z_ra = ctl.scan_k[ZAW-1:0];
            end
        endcase
    end

    tgi_ram #(.WIDTH(32), .DEPTH(T_POINTS)) u_t_axis (
        .clk(clk), .we(t_we), .waddr(address[TAW-1:0]), .wdata(load_value),
        .raddr(t_ra), .rdata(t_rd)
    );

    tgi_ram #(.WIDTH(32), .DEPTH(X_POINTS)) u_x_axis (
        .clk(clk), .we(x_we), .waddr(address[XAW-1:0]), .wdata(load_value),
        .raddr(x_ra), .rdata(x_rd)
    );

    tgi_ram #(.WIDTH(32), .DEPTH(Z_POINTS)) u_z_axis (
        .clk(clk), .we(z_we), .waddr(address[ZAW-1:0]), .wdata(load_value),
        .raddr(z_ra), .rdata(z_rd)
    );

    // Corner address from the cell base and the corner offsets
    assign corner_addr = base_reg
                       + (ctl.corner[2] ? plane_reg : '0)
                       + (ctl.corner[0] ? GRID_AW'(nz) : '0)
                       + GRID_AW'(ctl.corner[1]);

    tgi_ram #(.WIDTH(32), .DEPTH(1 << GRID_AW)) u_grid (
        .clk(clk), .we(cell_we), .waddr(address), .wdata(load_value),
        .raddr(corner_addr), .rdata(grid_rd)
    );

    // Loaded map: cleared by the sweep after reset, set by cell loads
    assign loaded_we = ctl.clear_we || cell_we;
    assign loaded_wa = ctl.clear_we ? ctl.clr_addr : address;

    tgi_ram #(.WIDTH(1), .DEPTH(1 << GRID_AW)) u_loaded (
        .clk(clk), .we(loaded_we), .waddr(loaded_wa), .wdata(!ctl.clear_we),
        .raddr(corner_addr), .rdata(loaded_rd)
    );

    // Divider operands for the selected axis
    always_comb
    begin
        unique case (ctl.axis)
            AX_X:
            begin
                q_sel  = qx_reg;
                lo_sel = x_lo_reg;
                hi_sel = x_hi_reg;
            end
            AX_Z:
            begin
                q_sel  = qz_reg;
                lo_sel = z_lo_reg;
                hi_sel = z_hi_reg;
            end
            default:
            begin
                q_sel  = qt_reg;
                lo_sel = t_lo_reg;
                hi_sel = t_hi_reg;
            end
        endcase
    end

    assign num33 = {q_sel[31], q_sel} - {lo_sel[31], lo_sel};
    assign den33 = {hi_sel[31], hi_sel} - {lo_sel[31], lo_sel};

    tgi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   ({num33, 16'h0000}),
        .den   (den33),
        .done  (div_done),
        .w     (div_w),
        .ovf   (div_ovf)
    );

    // Blend step: weight choice, difference and split product
    assign w_sel    = (ctl.step < 3'd4) ? wx_reg : ((ctl.step < 3'd6) ? wz_reg : wt_reg);
    assign d_diff   = {c_reg[1][31], c_reg[1]} - {c_reg[0][31], c_reg[0]};
    assign plo_prod = $signed({1'b0, d_diff[15:0]}) * w_sel;
    assign phi_prod = $signed(d_diff[32:16]) * w_sel;
    assign blend_raw = {{19{c_reg[0][31]}}, c_reg[0]} + {sum_reg[65], sum_reg[65:16]};
    assign dst       = 3'd6 - ctl.step;

    always_comb
    begin
        blend_clip = 1'b0;
        blend_res  = blend_raw[31:0];
        if (blend_raw > SAT_MAX)
        begin
            blend_clip = 1'b1;
            blend_res  = SAT_MAX[31:0];
        end
        else if (blend_raw < SAT_MIN)
        begin
            blend_clip = 1'b1;
            blend_res  = SAT_MIN[31:0];
        end
    end

    // Query working registers
    always_ff @(posedge clk)
    begin
        // Latch the query point
        if (ctl.start_query)
        begin
            qt_reg <= query_t;
            qx_reg <= query_x;
            qz_reg <= query_z;
        end

        // Count axis points at or below the query
        incl_t_reg <= ctl.scan_en && (ctl.scan_k < nt);
        incl_x_reg <= ctl.scan_en && (ctl.scan_k < nx);
        incl_z_reg <= ctl.scan_en && (ctl.scan_k < nz);
        if (ctl.start_query)
        begin
            ct_reg <= '0;
            cx_reg <= '0;
            cz_reg <= '0;
        end
        else
        begin
            if (incl_t_reg && ($signed(t_rd) <= qt_reg))
            begin
                ct_reg <= ct_reg + 1'b1;
            end
            if (incl_x_reg && ($signed(x_rd) <= qx_reg))
            begin
                cx_reg <= cx_reg + 1'b1;
            end
            if (incl_z_reg && ($signed(z_rd) <= qz_reg))
            begin
                cz_reg <= cz_reg + 1'b1;
            end
        end

        // Clamp counts to interval indexes
        if (ctl.mk_index)
        begin
            it_reg <= cell_index(ct_reg, nt);
            ix_reg <= cell_index(cx_reg, nx);
            iz_reg <= cell_index(cz_reg, nz);
        end

        // Capture interval end points
        if (ctl.cap_lo)
        begin
            t_lo_reg <= t_rd;
            x_lo_reg <= x_rd;
            z_lo_reg <= z_rd;
        end
        if (ctl.cap_hi)
        begin
            t_hi_reg <= t_rd;
            x_hi_reg <= x_rd;
            z_hi_reg <= z_rd;
        end

        // Cell base address in two multiply stages
        if (ctl.addr1)
        begin
            row_reg   <= GRID_AW'(it_reg) * GRID_AW'(nx) + GRID_AW'(ix_reg);
            plane_reg <= GRID_AW'(nx) * GRID_AW'(nz);
        end
        if (ctl.addr2)
        begin
            base_reg <= row_reg * GRID_AW'(nz) + GRID_AW'(iz_reg);
        end

        // Store finished weights
        if (ctl.div_store)
        begin
            unique case (ctl.axis)
                AX_X:    wx_reg <= div_w;
                AX_Z:    wz_reg <= div_w;
                default: wt_reg <= div_w;
            endcase
        end

        // Saturation and missing-corner flags
        if (ctl.start_query)
        begin
            sat_reg  <= 1'b0;
            miss_reg <= 1'b0;
        end
        else
        begin
            if ((ctl.div_store && div_ovf) || (ctl.fin && blend_clip))
            begin
                sat_reg <= 1'b1;
            end
            if (corner_v_reg && !loaded_rd)
            begin
                miss_reg <= 1'b1;
            end
        end

        // Corner capture in the cycle after the grid read
        corner_v_reg <= ctl.corner_en;
        corner_j_reg <= ctl.corner;
        if (corner_v_reg)
        begin
            c_reg[corner_j_reg] <= grid_rd;
        end

        // Split product and rounded sum
        if (ctl.mul_lo)
        begin
            plo_reg <= plo_prod;
        end
        if (ctl.mul_hi)
        begin
            phi_reg <= phi_prod;
        end
        if (ctl.blend_sum)
        begin
            sum_reg <= {phi_reg[48], phi_reg, 16'h0000} + {{17{plo_reg[48]}}, plo_reg}
                     + 66'sd32768;
        end

        // Drop the two consumed operands and queue the blend result
        if (ctl.fin)
        begin
            for (int k = 0; k < 8; k++)
            begin
                if (3'(k) == dst)
                begin
                    c_reg[k] <= blend_res;
                end
                else if (k < 6)
                begin
                    c_reg[k] <= c_reg[(k + 2) & 7];
                end
            end
        end

        // Output payload
        if (ctl.out_load)
        begin
            interp_reg   <= miss_reg ? 32'h0 : c_reg[0];
            miss_out_reg <= miss_reg;
            sat_out_reg  <= miss_reg ? 1'b0 : sat_reg;
        end
    end

    // Output valid: set on load, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign interpolated   = interp_reg;
    assign missing_corner = miss_out_reg;
    assign saturated      = sat_out_reg;

    assign st.scan_last = (ctl.scan_k == nmax - 1'b1);
    assign st.div_done  = div_done;
    assign st.out_free  = !out_valid_reg || out_ready;

endmodule

// ----- sv/tgi_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine that sequences loads and queries
`include "trilinear_grid_interpolator_defines.svh"
module tgi_ctrl
    import tgi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [2:0] command,
    output logic       in_ready,
    output tgi_ctl_t   ctl,
    input  tgi_sts_t   st
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [GRID_AW-1:0] clr_reg, clr_next;
    axis_t              axis_reg, axis_next;

    // Next state and counters
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        clr_next   = clr_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && (command == CMD_QUERY))
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = ST_SCAN_TAIL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SCAN_TAIL:   state_next = ST_INDEX;
            ST_INDEX:       state_next = ST_FETCH0;
            ST_FETCH0:      state_next = ST_FETCH1;
            ST_FETCH1:      state_next = ST_FETCH2;
            ST_FETCH2:      state_next = ST_ADDR1;
            ST_ADDR1:       state_next = ST_ADDR2;
            ST_ADDR2:
            begin
                axis_next  = AX_T;
                state_next = ST_DIV_START;
            end
            ST_DIV_START:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (st.div_done)
                begin
                    if (axis_reg == AX_Z)
                    begin
                        idx_next   = '0;
                        state_next = ST_CORNER;
                    end
                    else
                    begin
                        axis_next  = (axis_reg == AX_T) ? AX_X : AX_Z;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_CORNER:
            begin
                if (idx_reg[2:0] == 3'd7)
                begin
                    state_next = ST_CORNER_TAIL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_CORNER_TAIL:
            begin
                idx_next   = '0;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:      state_next = ST_MUL_HI;
            ST_MUL_HI:      state_next = ST_SUM;
            ST_SUM:         state_next = ST_FIN;
            ST_FIN:
            begin
                if (idx_reg[2:0] == 3'd6)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_MUL_LO;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        in_ready        = 1'b0;
        ctl.clear_we    = 1'b0;
        ctl.clr_addr    = clr_reg;
        ctl.start_query = 1'b0;
        ctl.scan_en     = 1'b0;
        ctl.scan_k      = idx_reg;
        ctl.mk_index    = 1'b0;
        ctl.rsel        = RS_SCAN;
        ctl.cap_lo      = 1'b0;
        ctl.cap_hi      = 1'b0;
        ctl.addr1       = 1'b0;
        ctl.addr2       = 1'b0;
        ctl.div_start   = 1'b0;
        ctl.div_store   = 1'b0;
        ctl.axis        = axis_reg;
        ctl.corner_en   = 1'b0;
        ctl.corner      = idx_reg[2:0];
        ctl.mul_lo      = 1'b0;
        ctl.mul_hi      = 1'b0;
        ctl.blend_sum   = 1'b0;
        ctl.fin         = 1'b0;
        ctl.step        = idx_reg[2:0];
        ctl.out_load    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:       ctl.clear_we = 1'b1;
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                ctl.start_query = in_valid && (command == CMD_QUERY);
            end
            ST_SCAN:        ctl.scan_en = 1'b1;
            ST_SCAN_TAIL:   ctl.scan_en = 1'b0;
            ST_INDEX:       ctl.mk_index = 1'b1;
            ST_FETCH0:      ctl.rsel = RS_LO;
            ST_FETCH1:
            begin
                ctl.rsel   = RS_HI;
                ctl.cap_lo = 1'b1;
            end
            ST_FETCH2:      ctl.cap_hi = 1'b1;
            ST_ADDR1:       ctl.addr1 = 1'b1;
            ST_ADDR2:       ctl.addr2 = 1'b1;
            ST_DIV_START:   ctl.div_start = 1'b1;
            ST_DIV_WAIT:    ctl.div_store = st.div_done;
            ST_CORNER:      ctl.corner_en = 1'b1;
            ST_CORNER_TAIL: ctl.corner_en = 1'b0;
            ST_MUL_LO:      ctl.mul_lo = 1'b1;
            ST_MUL_HI:      ctl.mul_hi = 1'b1;
            ST_SUM:         ctl.blend_sum = 1'b1;
            ST_FIN:         ctl.fin = 1'b1;
            ST_DONE:        ctl.out_load = st.out_free;
            default:        in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            idx_reg   <= '0;
            clr_reg   <= '0;
            axis_reg  <= AX_T;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            clr_reg   <= clr_next;
            axis_reg  <= axis_next;
        end
    end

    // Only the idle state takes a transfer
    `TGI_ASSERT_NOW(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE, "ready outside idle")
    // A query transfer starts the axis scan
    `TGI_ASSERT_NEXT(a_query_scan, clk, rst_n, state_reg == ST_IDLE && in_valid && command == CMD_QUERY, state_reg == ST_SCAN, "query did not start scan")
    // A blocked result holds the controller
    `TGI_ASSERT_NEXT(a_done_hold, clk, rst_n, state_reg == ST_DONE && !st.out_free, state_reg == ST_DONE && !ctl.start_query, "result dropped while output full")

endmodule
